// File: hdl/ucr_pkg.sv
// Shared types and byte-class constants for the UTF-8 character reframer.
package ucr_pkg;

  localparam int unsigned DEPTH = 4;

  // Byte-class masks and patterns.
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  typedef logic [DEPTH-1:0][7:0] byte_buf_t;

  // Outcome of one scan step at the head of the byte store.
  typedef struct packed {
    logic        done;   // store empty or head lead still lacks bytes
    logic        found;  // a complete, valid character sits at the head
    logic [2:0]  shift;  // bytes to drop from the head
    logic [2:0]  len;    // character length when found
    logic [31:0] bytes;  // packed character, unused upper bytes zero
  } scan_step_t;

endpackage

// File: hdl/utf8_char_reframer.sv
// Top level of the UTF-8 character reframer: byte store, scan sequencer, result register.
// Scan: an accepted beat is scanned one head position per cycle unless the result register is
//   full; a scan is up to 4 byte drops plus the closing step, done by the scan unit.
// Flow control: in_stall is high for the whole scan, so a new input beat waits until the scan
//   of the last one ends, and up to 3 result beats leave per input beat.
// Reset (rst_n low, synchronous): clears the byte count, the sequencer and all valid
//   flags; the byte store itself is not cleared, only counted entries are ever read.
module utf8_char_reframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_end,   // software write boundary, no effect on decoding
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_char_bytes,
  output logic [2:0]  out_char_len,
  output logic        out_last_of_run
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;

  // Byte store, oldest byte at index 0, and its fill count.
  ucr_pkg::byte_buf_t buf_r, buf_nxt;
  logic [2:0]         count_r, count_nxt;

  // One character waits here until we know whether another follows it,
  // which decides its last_of_run flag.
  logic        hold_valid_r, hold_valid_nxt;
  logic [31:0] hold_bytes_r, hold_bytes_nxt;
  logic [2:0]  hold_len_r, hold_len_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_bytes_r, out_bytes_nxt;
  logic [2:0]  out_len_r, out_len_nxt;
  logic        out_last_r, out_last_nxt;

  ucr_pkg::scan_step_t step;
  logic                out_free;

  ucr_scan_step u_scan (
    .buf_i   (buf_r),
    .count_i (count_r),
    .step_o  (step)
  );

  // The result register can take a new beat this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    count_nxt      = count_r;
    hold_valid_nxt = hold_valid_r;
    hold_bytes_nxt = hold_bytes_r;
    hold_len_nxt   = hold_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_bytes_nxt  = out_bytes_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        // Append the new byte behind the pending ones (at most three remain).
        if (in_valid) begin
          buf_nxt[count_r[1:0]] = in_data_byte;
          count_nxt             = count_r + 3'd1;
          state_nxt             = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step.done) begin
          // Scan over: release the held character as the last of the run.
          if (!hold_valid_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_bytes_nxt  = hold_bytes_r;
            out_len_nxt    = hold_len_r;
            out_last_nxt   = 1'b1;
            hold_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else if (!step.found || !hold_valid_r || out_free) begin
          // Hold the scan only when a second character finds the result register full.
          if (step.found) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_bytes_nxt = hold_bytes_r;
              out_len_nxt   = hold_len_r;
              out_last_nxt  = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_bytes_nxt = step.bytes;
            hold_len_nxt   = step.len;
          end
          // Advance the store past the consumed or dropped bytes.
          case (step.shift)
            3'd1:    buf_nxt = ucr_pkg::byte_buf_t'(buf_r >> 8);
            3'd2:    buf_nxt = ucr_pkg::byte_buf_t'(buf_r >> 16);
            3'd3:    buf_nxt = ucr_pkg::byte_buf_t'(buf_r >> 24);
            default: buf_nxt = buf_r;
          endcase
          count_nxt = count_r - step.shift;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= 3'd0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    buf_r        <= buf_nxt;
    hold_bytes_r <= hold_bytes_nxt;
    hold_len_r   <= hold_len_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char_bytes  = out_bytes_r;
  assign out_char_len    = out_len_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  // Between beats only an incomplete lead stays pending.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r <= 3'd3))
    else $error("more than three bytes pending between beats");

  // Every held character is flushed before the next beat is taken.
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("held character left over at end of scan");

  // An accepted beat always starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted beat did not start a scan");

  // Result lengths are one to four bytes.
  a_out_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_len >= 3'd1 && out_char_len <= 3'd4))
    else $error("result length out of range");
`endif

endmodule

// File: hdl/ucr_scan_step.sv
// Shared scan unit: classifies the head byte and checks its continuation bytes.
module ucr_scan_step (
  input  ucr_pkg::byte_buf_t  buf_i,
  input  logic [2:0]          count_i,
  output ucr_pkg::scan_step_t step_o
);

  logic [2:0] lead_len;
  logic       cont_ok;

  always_comb begin
    if ((buf_i[0] & ucr_pkg::MASK_ASCII) == 8'h00) begin
      lead_len = 3'd1;
    end else if ((buf_i[0] & ucr_pkg::MASK_LEAD2) == ucr_pkg::PAT_LEAD2) begin
      lead_len = 3'd2;
    end else if ((buf_i[0] & ucr_pkg::MASK_LEAD3) == ucr_pkg::PAT_LEAD3) begin
      lead_len = 3'd3;
    end else if ((buf_i[0] & ucr_pkg::MASK_LEAD4) == ucr_pkg::PAT_LEAD4) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  always_comb begin
    cont_ok = 1'b1;
    for (int i = 1; i < ucr_pkg::DEPTH; i++) begin
      if ((3'(i) < lead_len) && ((buf_i[i] & ucr_pkg::MASK_CONT) != ucr_pkg::PAT_CONT)) begin
        cont_ok = 1'b0;
      end
    end
  end

  always_comb begin
    step_o = '0;
    if (count_i == 3'd0) begin
      step_o.done = 1'b1;
    end else if (lead_len == 3'd0) begin
      step_o.shift = 3'd1;                    // drop stray byte
    end else if (lead_len > count_i) begin
      step_o.done = 1'b1;                     // hold incomplete lead
    end else if (cont_ok) begin
      step_o.found = 1'b1;
      step_o.shift = lead_len;
      step_o.len   = lead_len;
      for (int i = 0; i < ucr_pkg::DEPTH; i++) begin
        if (3'(i) < lead_len) begin
          step_o.bytes[8*i +: 8] = buf_i[i];
        end
      end
    end else begin
      step_o.shift = 3'd1;                    // drop lead only, rescan
    end
  end

endmodule

// File: dv/ucr_frame_checker.sv
// Checker for the UTF-8 character reframer: byte-to-character predictor and result comparison.
module ucr_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_char_bytes,
  input  logic [2:0]  out_char_len,
  input  logic        out_last_of_run,
  output int          mismatches,
  output int          chars_owed,
  output int          chars_checked,
  output int          widest_run
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PAT_ASCII = 8'h00;
  localparam int unsigned MAX_RUN = 3;

  typedef struct packed {
    logic [31:0] chr;
    logic [2:0]  nbytes;
    logic        last_flag;
  } char_beat_t;

  logic [7:0]  held [0:ucr_pkg::DEPTH-1];
  int unsigned held_n;
  char_beat_t  char_q [$];

  // Character length announced by a byte at the scan position, 0 for a stray byte.
  function automatic int unsigned lead_span(logic [7:0] b);
    if ((b & ucr_pkg::MASK_ASCII) == PAT_ASCII) return 1;
    if ((b & ucr_pkg::MASK_LEAD2) == ucr_pkg::PAT_LEAD2) return 2;
    if ((b & ucr_pkg::MASK_LEAD3) == ucr_pkg::PAT_LEAD3) return 3;
    if ((b & ucr_pkg::MASK_LEAD4) == ucr_pkg::PAT_LEAD4) return 4;
    return 0;
  endfunction

  // Append one byte to the held bytes, rescan from the oldest and queue the characters found.
  task automatic frame_byte(input logic [7:0] b);
    logic [7:0]  win [0:ucr_pkg::DEPTH-1];
    char_beat_t  found [0:MAX_RUN-1];
    logic [31:0] chr_word;
    int unsigned n, pos, span, i, cnt;
    bit          good;
    n   = held_n;
    pos = 0;
    cnt = 0;
    for (i = 0; i < n; i++) win[i] = held[i];
    win[n] = b;
    n++;
    while (pos < n) begin
      span = lead_span(win[pos]);
      if (span == 0) begin
        pos++;
        continue;
      end
      if (pos + span > n) break;
      good = 1'b1;
      for (i = 1; i < span; i++) begin
        if ((win[pos+i] & ucr_pkg::MASK_CONT) != ucr_pkg::PAT_CONT) good = 1'b0;
      end
      if (good) begin
        chr_word = '0;
        for (i = 0; i < span; i++) chr_word[8*i +: 8] = win[pos+i];
        if (cnt < MAX_RUN) begin
          found[cnt] = '{chr: chr_word, nbytes: 3'(span), last_flag: 1'b0};
          cnt++;
        end
        pos += span;
      end else begin
        // bad continuation: drop the lead only
        pos++;
      end
    end
    if (cnt > 0) found[cnt-1].last_flag = 1'b1;
    for (i = 0; i < cnt; i++) char_q.push_back(found[i]);
    if (int'(cnt) > widest_run) widest_run = int'(cnt);
    held_n = n - pos;
    for (i = pos; i < n; i++) held[i-pos] = win[i];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on %s at result beat %0d: expected %h, got %h",
             what, chars_checked, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      held_n        = 0;
      mismatches    = 0;
      chars_checked = 0;
      widest_run    = 0;
      char_q.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) frame_byte(in_data_byte);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (char_q.size() == 0) begin
          report_mismatch("unexpected beat", '0, out_char_bytes);
        end else begin
          want = char_q.pop_front();
          if (out_char_bytes !== want.chr)
            report_mismatch("char_bytes", want.chr, out_char_bytes);
          if (out_char_len !== want.nbytes)
            report_mismatch("char_len", 32'(want.nbytes), 32'(out_char_len));
          if (out_last_of_run !== want.last_flag)
            report_mismatch("last_of_run", 32'(want.last_flag), 32'(out_last_of_run));
        end
        chars_checked++;
      end else if (out_valid !== 1'b0 && out_valid !== 1'b1) begin
        report_mismatch("out_valid unknown", '0, 32'(out_valid));
      end
    end
    chars_owed = char_q.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the reframer testbench: clock, reset, byte stimulus, result-side stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS          = 220;
  localparam int unsigned HOLD_CYCLES    = 120;  // long receiver hold-off
  localparam int unsigned TAIL_CYCLES    = 20;   // margin after the last scan
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_chunk_end;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_char_bytes;
  logic [2:0]  out_char_len;
  logic        out_last_of_run;

  int          mismatches;
  int          chars_owed;
  int          chars_checked;
  int          widest_run;

  int unsigned n_sent;
  int unsigned idle_cycles;
  bit          hold_req;  // set by the sender, taken and cleared by the result side
  bit          quiet;     // no gaps and no stalls while set

  utf8_char_reframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_chunk_end    (in_chunk_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_bytes  (out_char_bytes),
    .out_char_len    (out_char_len),
    .out_last_of_run (out_last_of_run)
  );

  ucr_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_bytes  (out_char_bytes),
    .out_char_len    (out_char_len),
    .out_last_of_run (out_last_of_run),
    .mismatches      (mismatches),
    .chars_owed      (chars_owed),
    .chars_checked   (chars_checked),
    .widest_run      (widest_run)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: count cycles in which neither channel moves a beat; give up at the limit.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Gap before a beat: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one byte at the falling edge and hold it until the block takes it. With no gap the
  // valid stays high, so it is never lowered and raised within one step.
  task automatic send_beat(input logic [7:0] b, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_chunk_end <= 1'($urandom_range(0, 1));
    do @(posedge clk); while (in_stall !== 1'b0);
    n_sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned span);
    logic [7:0] r;
    r = 8'($urandom);
    case (span)
      1: begin
        return {1'b0, r[6:0]};
      end
      2: begin
        return {3'b110, r[4:0]};
      end
      3: begin
        return {4'b1110, r[3:0]};
      end
      default: begin
        return {5'b11110, r[2:0]};
      end
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // Send a character of span bytes; cut it after n_cont continuations to break it.
  task automatic send_char(input int unsigned span, input int unsigned n_cont, input bit gaps);
    send_beat(lead_byte(span), gaps ? pick_gap() : 0);
    repeat (n_cont) send_beat(cont_byte(), gaps ? pick_gap() : 0);
  endtask

  // Drop valid and hold the sender until every predicted character has come out.
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chars_owed != 0) @(negedge clk);
  endtask

  // Result side: runs of free and stalled cycles, plus the long hold-off on request.
  initial begin : result_side
    int unsigned run;
    int unsigned r;
    bit          level;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        level    = 1'b1;
        run      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (quiet || r < 60) begin
        level = 1'b0;
        run   = quiet ? 1 : $urandom_range(1, 4);
      end else if (r < 92) begin
        level = 1'b1;
        run   = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        run   = $urandom_range(10, 30);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= level;
      end
    end
  end

  initial begin : byte_source
    // extremes of ASCII, the longest valid sequences, stray bytes, a lead broken by three
    // ASCII bytes (three characters from one byte) and a lead broken by another lead
    logic [7:0]  directed [$] = '{8'h00, 8'h7F,
                                  8'hC2, 8'hA9,
                                  8'hEF, 8'hBF, 8'hBF,
                                  8'hF7, 8'hBF, 8'hBF, 8'hBF,
                                  8'h80, 8'hF8, 8'hFF,
                                  8'hF0, 8'h41, 8'h42, 8'h43,
                                  8'hC3, 8'hC3, 8'hA9};
    int unsigned r;
    int unsigned span;
    bit          hold_done;
    bit          pause_done;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_chunk_end = 1'b0;
    hold_req     = 1'b0;
    quiet        = 1'b0;
    n_sent       = 0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_beat(directed[i], pick_gap());
    drain_wait();

    while (n_sent < ITEMS) begin
      // Fill the block: long receiver hold-off while bytes keep coming back to back.
      if (!hold_done && n_sent >= 80) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (16) send_char(1, 0, 1'b0);
      end
      // Let the pipe run dry once before going on.
      if (!pause_done && n_sent >= 170) begin
        pause_done = 1'b1;
        drain_wait();
      end
      quiet = (n_sent >= 120 && n_sent < 150);

      r    = $urandom_range(0, 99);
      span = $urandom_range(1, 4);
      if (r < 75) begin
        send_char(span, span - 1, 1'b1);
      end else if (r < 88) begin
        // broken sequence: the next lead arrives too early
        span = $urandom_range(2, 4);
        send_char(span, $urandom_range(0, span - 2), 1'b1);
      end else begin
        send_beat(8'($urandom_range(0, 255)), pick_gap());
      end
    end
    quiet = 1'b0;

    drain_wait();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d bytes, checked %0d characters", n_sent, chars_checked);
    $display("up to %0d characters came from one byte", widest_run);
    if (mismatches == 0 && chars_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
